/* src/phgd_pkg.sv */
package phgd_pkg;

  localparam int unsigned MaxElements = 4194304;
  localparam int unsigned MaxDim = 4096;
  localparam int unsigned IdxW = 22;
  localparam int unsigned DimW = 13;
  localparam int unsigned PosW = 12;

  localparam logic [1:0] RegRows = 2'd0;
  localparam logic [1:0] RegColumns = 2'd1;
  localparam logic [1:0] RegChannels = 2'd2;

  typedef struct packed {
    logic [7:0] diff_low;
    logic [7:0] diff_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [21:0] dest_index;
    logic        not_finite;
    logic        last;
  } out_item_t;

  function automatic logic [63:0] half_to_double(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [9:0]  frac;
    logic [63:0] r;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    r = '0;
    r[63] = h[15];
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    frac = m << (4'd10 - p);
    if (e == 5'd31) begin
      r[62:52] = 11'h7FF;
      r[51:42] = m;
    end else if (e == 5'd0) begin
      if (m != 10'd0) begin
        r[62:52] = 11'(11'd999 + 11'(p));
        r[51:42] = frac;
      end
    end else begin
      r[62:52] = 11'(11'd1008 + 11'(e));
      r[51:42] = m;
    end
    return r;
  endfunction

endpackage

/* src/phgd_walk.sv */
module phgd_walk (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic                   advance,
  input  logic [phgd_pkg::DimW-1:0] nr,
  input  logic [phgd_pkg::DimW-1:0] nc,
  input  logic [phgd_pkg::DimW-1:0] nk,
  input  logic [phgd_pkg::IdxW-1:0] row_stride,
  output logic [phgd_pkg::IdxW-1:0] cur_index,
  output logic                   end_col,
  output logic                   end_grid
);
  import phgd_pkg::*;

  logic [PosW-1:0] col_pos, row_pos, chan_pos;
  logic [PosW-1:0] chan_pos_next;
  logic [IdxW-1:0] row_start_index;
  logic end_row, end_chan;

  assign end_col  = DimW'(col_pos) + 1'b1 >= nc;
  assign end_row  = DimW'(row_pos) + 1'b1 >= nr;
  assign end_chan = DimW'(chan_pos) + 1'b1 >= nk;
  assign end_grid = end_col && end_row && end_chan;
  assign chan_pos_next = end_chan ? '0 : chan_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_pos <= '0;
      row_pos <= '0;
      chan_pos <= '0;
      cur_index <= '0;
      row_start_index <= '0;
    end else if (advance) begin
      if (!end_col) begin
        col_pos <= col_pos + 1'b1;
        cur_index <= cur_index + IdxW'(nk);
      end else begin
        col_pos <= '0;
        if (!end_row) begin
          row_pos <= row_pos + 1'b1;
          row_start_index <= row_start_index + row_stride;
          cur_index <= row_start_index + row_stride;
        end else begin
          row_pos <= '0;
          chan_pos <= chan_pos_next;
          row_start_index <= IdxW'(chan_pos_next);
          cur_index <= IdxW'(chan_pos_next);
        end
      end
    end
  end

endmodule

/* src/packed_half_grid_decoder_core.sv */
// An accepted request loads the result register and steps the running sum and walk counters.
// Throughput: one request per cycle, except while a pending result is held by out_stall.
// Row stride (columns*channels) is formed combinationally from the live dimensions.
// Reset: synchronous; all dimensions become 1, walk and running sum clear, no result pending.
module packed_half_grid_decoder_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  phgd_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output phgd_pkg::out_item_t   out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import phgd_pkg::*;

  logic [DimW-1:0] grid_rows, grid_columns, grid_channels;
  logic [DimW-1:0] nr, nc, nk;
  logic [IdxW-1:0] row_stride;
  logic [15:0] prev_half, bits;
  logic [IdxW-1:0] cur_index;
  logic end_col, end_grid, cfg_wr, restart, accept;
  logic [1:0] reg_sel;

  function automatic logic [DimW-1:0] eff(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(MaxDim)) return DimW'(MaxDim);
    return v;
  endfunction

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (reg_sel == RegRows || reg_sel == RegColumns ||
                              reg_sel == RegChannels);

  always_comb begin
    case (reg_sel)
      RegRows:     prdata = 32'(grid_rows);
      RegColumns:  prdata = 32'(grid_columns);
      RegChannels: prdata = 32'(grid_channels);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= DimW'(1);
      grid_columns <= DimW'(1);
      grid_channels <= DimW'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        RegRows:     grid_rows <= pwdata[DimW-1:0];
        RegColumns:  grid_columns <= pwdata[DimW-1:0];
        RegChannels: grid_channels <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  assign nr = eff(grid_rows);
  assign nc = eff(grid_columns);
  assign nk = eff(grid_channels);

  assign row_stride = IdxW'(nc) * IdxW'(nk);

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;
  assign bits = prev_half + {in_data.diff_high, in_data.diff_low};

  phgd_walk u_walk (
    .clk(clk), .rst(rst), .restart(restart), .advance(accept),
    .nr(nr), .nc(nc), .nk(nk), .row_stride(row_stride),
    .cur_index(cur_index), .end_col(end_col), .end_grid(end_grid)
  );

  always_ff @(posedge clk) begin
    if (rst || restart) prev_half <= '0;
    else if (accept) prev_half <= end_col ? 16'd0 : bits;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (accept) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.value_bits <= half_to_double(bits);
      out_data.dest_index <= cur_index;
      out_data.not_finite <= bits[14:10] == 5'd31;
      out_data.last <= end_grid;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> prev_half == 16'd0)
    else $error("running sum not cleared on config write");
  a_nf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.not_finite == (out_data.value_bits[62:52] == 11'h7FF))
    else $error("not_finite mismatch");

endmodule

/* test/packed_half_grid_decoder_core_test.sv */
module packed_half_grid_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import phgd_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    logic [7:0]  lo;
    logic [7:0]  hi;
    bit          typed;
    logic [63:0] bits;
    logic        nf;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  packed_half_grid_decoder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  int unsigned dim_rows, dim_cols, dim_chans;
  logic [15:0] run_half;
  int unsigned col_at, row_at, chan_at;
  int unsigned index_at, row_base;

  out_item_t decoded_q[$];
  int unsigned failures;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned last_seen;
  int unsigned nonfinite_seen;
  int unsigned idle_cycles;
  bit sink_quiet;
  bit long_hold;
  bit calm;
  bit done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic logic [63:0] widen_half(input logic [15:0] h);
    logic [63:0] r;
    int p;
    r = '0;
    r[63] = h[15];
    if (h[14:10] == 5'd31) begin
      r[62:52] = 11'h7FF;
      r[51:42] = h[9:0];
    end else if (h[14:10] == 5'd0) begin
      if (h[9:0] != 0) begin
        p = 9;
        while (!h[p]) p--;
        r[62:52] = 11'(1023 + p - 24);
        r[51:0] = 52'(h[9:0] - (10'd1 << p)) << (52 - p);
      end
    end else begin
      r[62:52] = 11'(h[14:10] + 1008);
      r[51:42] = h[9:0];
    end
    return r;
  endfunction

  task automatic restart_walk();
    run_half = 0;
    col_at = 0;
    row_at = 0;
    chan_at = 0;
    index_at = 0;
    row_base = 0;
  endtask

  function automatic out_item_t decode_next(input logic [7:0] lo, input logic [7:0] hi);
    out_item_t o;
    logic [15:0] h;
    bit ec, er, ek;
    h = run_half + {hi, lo};
    ec = col_at + 1 >= dim_cols;
    er = row_at + 1 >= dim_rows;
    ek = chan_at + 1 >= dim_chans;
    run_half = h;
    o.value_bits = widen_half(h);
    o.dest_index = index_at[21:0];
    o.not_finite = h[14:10] == 5'd31;
    o.last = ec && er && ek;
    if (!ec) begin
      col_at++;
      index_at = (index_at + dim_chans) % MaxElements;
    end else begin
      col_at = 0;
      run_half = 0;
      if (!er) begin
        row_at++;
        row_base = (row_base + dim_cols * dim_chans) % MaxElements;
      end else begin
        row_at = 0;
        chan_at = ek ? 0 : chan_at + 1;
        row_base = chan_at % MaxElements;
      end
      index_at = row_base;
    end
    return o;
  endfunction

  task automatic send_request(input logic [7:0] lo, input logic [7:0] hi);
    in_valid <= 1'b1;
    in_data <= '{diff_low: lo, diff_high: hi};
    do @(posedge clk); while (in_stall);
    decoded_q.push_back(decode_next(lo, hi));
    requests_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {19'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegRows: dim_rows = clamp_dim(v);
      RegColumns: dim_cols = clamp_dim(v);
      default: dim_chans = clamp_dim(v);
    endcase
    restart_walk();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_grid(input logic [12:0] r, input logic [12:0] c, input logic [12:0] k);
    drain();
    write_reg(RegRows, r);
    write_reg(RegColumns, c);
    write_reg(RegChannels, k);
  endtask

  task automatic send_grid_burst(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_request(8'($urandom), 8'($urandom));
      else
        send_request(8'($urandom_range(0, 15)), $urandom_range(0, 1) ? 8'h00 : 8'hFF);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.last) last_seen++;
        if (out_data.not_finite) nonfinite_seen++;
        if (decoded_q.size() == 0) begin
          failures++;
          if (mismatches < 10) $display("unexpected result %p", out_data);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.value_bits !== want.value_bits ||
              out_data.dest_index !== want.dest_index ||
              out_data.not_finite !== want.not_finite ||
              out_data.last !== want.last) begin
            failures++;
            if (mismatches < 10)
              $display("mismatch: expected %h %0d %b %b, got %h %0d %b %b",
                       want.value_bits, want.dest_index, want.not_finite, want.last,
                       out_data.value_bits, out_data.dest_index, out_data.not_finite,
                       out_data.last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (!sink_quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      sink_quiet = 1'b1;
      fork
        begin
          repeat ($urandom_range(1, 10)) @(negedge clk);
          sink_quiet = 1'b0;
        end
      join_none
    end else if (!sink_quiet) begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    @(posedge clk);
    wait (!rst);
    while (!done) begin
      @(posedge clk);
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchLimit);
        $display("[packed_half_grid_decoder_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    row_t plan[$];
    out_item_t want;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failures = 0;
    mismatches = 0;
    requests_sent = 0;
    results_seen = 0;
    last_seen = 0;
    nonfinite_seen = 0;
    idle_cycles = 0;
    sink_quiet = 0;
    long_hold = 0;
    calm = 0;
    done = 0;
    dim_rows = 1;
    dim_cols = 1;
    dim_chans = 1;
    restart_walk();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    plan.push_back('{8'h00, 8'h00, 1, 64'h0, 1'b0});
    plan.push_back('{8'h00, 8'h80, 1, 64'h8000_0000_0000_0000, 1'b0});
    plan.push_back('{8'h00, 8'h7C, 1, 64'h7FF0_0000_0000_0000, 1'b1});
    plan.push_back('{8'h00, 8'hFC, 1, 64'hFFF0_0000_0000_0000, 1'b1});
    plan.push_back('{8'hFF, 8'hFF, 1, 64'hFFFF_FC00_0000_0000, 1'b1});
    plan.push_back('{8'h00, 8'h3C, 1, 64'h3FF0_0000_0000_0000, 1'b0});
    plan.push_back('{8'h01, 8'h00, 1, 64'h3E70_0000_0000_0000, 1'b0});
    plan.push_back('{8'hFF, 8'h7B, 0, 0, 0});
    plan.push_back('{8'hFF, 8'h03, 0, 0, 0});
    plan.push_back('{8'h00, 8'h04, 0, 0, 0});
    plan.push_back('{8'h55, 8'hAA, 0, 0, 0});
    plan.push_back('{8'hAA, 8'h55, 0, 0, 0});
    foreach (plan[i]) begin
      want = decode_next(plan[i].lo, plan[i].hi);
      if (plan[i].typed && (want.value_bits !== plan[i].bits || want.not_finite !== plan[i].nf
          || want.last !== 1'b1 || want.dest_index !== 0)) begin
        failures++;
        $display("table row %0d disagrees with decoder prediction", i);
      end
      run_half = 0;
    end
    restart_walk();
    foreach (plan[i]) send_request(plan[i].lo, plan[i].hi);

    set_grid(13'd2, 13'd3, 13'd2);
    send_request(8'h00, 8'h3C);
    send_request(8'h00, 8'h40);
    send_request(8'h00, 8'h80);
    send_request(8'h01, 8'h00);
    send_request(8'hFF, 8'hFF);
    send_request(8'h00, 8'h7C);
    send_grid_burst(6);
    set_grid(13'd0, 13'd5000, 13'd0);
    send_grid_burst(5);
    set_grid(13'd4096, 13'd4096, 13'd4096);
    send_grid_burst(5);
    set_grid(13'h1FFF, 13'd1, 13'd4095);
    send_grid_burst(4);

    for (int phase = 0; phase < 12; phase++) begin
      set_grid(13'($urandom_range(0, 4)), 13'($urandom_range(0, 12)),
               13'($urandom_range(0, 3)));
      if (phase == 3) begin
        long_hold = 1'b1;
        fork
          begin
            repeat (60) @(negedge clk);
            long_hold = 1'b0;
          end
        join_none
      end
      if (phase == 10) calm = 1'b1;
      send_grid_burst(160);
    end
    drain();
    repeat (5) @(posedge clk);

    $display("sent %0d requests over varied grid shapes; %0d results, %0d grid ends,",
             requests_sent, results_seen, last_seen);
    $display("%0d non-finite values, %0d mismatches", nonfinite_seen, mismatches);
    done = 1'b1;
    if (failures == 0 && decoded_q.size() == 0) begin
      $display("[packed_half_grid_decoder_core] OK");
    end else begin
      $display("[packed_half_grid_decoder_core] ERROR");
    end
    $finish;
  end
endmodule
